### sv/u2u8_pkg.sv
// Shared types and constants for the UCS-2 to UTF-8 stream converter.
`timescale 1ns / 1ps
`default_nettype none
package u2u8_pkg;

   localparam int unsigned Q_DEPTH = 2;
   localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [15:0] BOM_NATIVE  = 16'hFEFF;
   localparam logic [15:0] BOM_SWAPPED = 16'hFFFE;
   localparam logic [15:0] ONE_BYTE_MAX = 16'd127;
   localparam logic [15:0] TWO_BYTE_MAX = 16'd2047;

   localparam logic [2:0] LEAD2_TAG = 3'b110;
   localparam logic [3:0] LEAD3_TAG = 4'b1110;
   localparam logic [1:0] CONT_TAG  = 2'b10;

   // index of the final output byte of a queued code unit
   typedef logic [1:0] byte_idx_type;

   localparam byte_idx_type LAST_IDX_1 = 2'd0;
   localparam byte_idx_type LAST_IDX_2 = 2'd1;
   localparam byte_idx_type LAST_IDX_3 = 2'd2;

   typedef struct packed {
      logic         odd_err;
      byte_idx_type last_idx;
      logic [15:0]  unit;
   } unit_entry_type;

endpackage
`default_nettype wire

### sv/ucs2_to_utf8_stream_core.sv
// Top level of the UCS-2 byte stream to UTF-8 byte stream converter.
//
//   channel  direction  ports
//   req      in         req_valid/req_ready, req_data_byte, req_end_of_stream
//   rsp      out        rsp_valid/rsp_ready, rsp_out_byte, rsp_last_of_run, rsp_odd_length_error
//
// A request is taken every cycle while the two-entry unit queue has room.
// Each code unit drains as 1 to 3 output bytes, one per cycle while rsp_ready is
// high, so the output port sets the rate: at worst 3 bytes per 2-byte unit. A unit
// is registered in a queue slot and then in the output register. Reset is synchronous
// and empties the queue and output register. Output stalls back up through the queue only.
`timescale 1ns / 1ps
`default_nettype none
module ucs2_to_utf8_stream_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_stream,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last_of_run,
   output logic            rsp_odd_length_error
);

   logic                     push_valid;
   logic                     push_ready;
   u2u8_pkg::unit_entry_type push_entry;
   logic                     pop_valid;
   logic                     pop_ready;
   u2u8_pkg::unit_entry_type pop_entry;

   u2u8_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .push_valid        (push_valid),
      .push_entry        (push_entry),
      .push_ready        (push_ready)
   );

   u2u8_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   u2u8_back u_back (
      .clock                (clock),
      .reset                (reset),
      .pop_valid            (pop_valid),
      .pop_entry            (pop_entry),
      .pop_ready            (pop_ready),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_last_of_run      (rsp_last_of_run),
      .rsp_odd_length_error (rsp_odd_length_error)
   );

endmodule
`default_nettype wire

### sv/u2u8_front.sv
// Front end: pairs bytes into code units, handles the byte order mark, classifies length.
`timescale 1ns / 1ps
`default_nettype none
module u2u8_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [7:0]               req_data_byte,
   input  wire logic                     req_end_of_stream,
   output logic                          push_valid,
   output u2u8_pkg::unit_entry_type      push_entry,
   input  wire logic                     push_ready
);

   logic       first_pending_ff, first_pending_in;
   logic       half_held_ff, half_held_in;
   logic       little_endian_ff, little_endian_in;
   logic [7:0] held_byte_ff, held_byte_in;

   logic        accept;
   logic [15:0] le_unit;
   logic [15:0] be_unit;
   logic [15:0] sel_unit;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;
   assign le_unit   = {req_data_byte, held_byte_ff};
   assign be_unit   = {held_byte_ff, req_data_byte};

   always_comb begin
      first_pending_in = first_pending_ff;
      half_held_in     = half_held_ff;
      little_endian_in = little_endian_ff;
      held_byte_in     = held_byte_ff;
      push_valid       = 1'b0;
      sel_unit         = little_endian_ff ? le_unit : be_unit;
      if (accept) begin
         if (!half_held_ff) begin
            held_byte_in = req_data_byte;
            half_held_in = 1'b1;
            if (req_end_of_stream) begin
               push_valid   = 1'b1;
               half_held_in = 1'b0;
            end
         end else begin
            half_held_in = 1'b0;
            if (first_pending_ff) begin
               first_pending_in = 1'b0;
               sel_unit         = le_unit;
               if (le_unit == u2u8_pkg::BOM_NATIVE) begin
                  little_endian_in = 1'b1;
               end else if (le_unit == u2u8_pkg::BOM_SWAPPED) begin
                  little_endian_in = 1'b0;
               end else begin
                  little_endian_in = 1'b1;
                  push_valid       = 1'b1;
               end
            end else begin
               push_valid = 1'b1;
            end
         end
         if (req_end_of_stream) begin
            first_pending_in = 1'b1;
            little_endian_in = 1'b1;
         end
      end
   end

   always_comb begin
      push_entry.odd_err = !half_held_ff;
      push_entry.unit    = sel_unit;
      if (!half_held_ff) begin
         push_entry.last_idx = u2u8_pkg::LAST_IDX_1;
      end else if (sel_unit <= u2u8_pkg::ONE_BYTE_MAX) begin
         push_entry.last_idx = u2u8_pkg::LAST_IDX_1;
      end else if (sel_unit <= u2u8_pkg::TWO_BYTE_MAX) begin
         push_entry.last_idx = u2u8_pkg::LAST_IDX_2;
      end else begin
         push_entry.last_idx = u2u8_pkg::LAST_IDX_3;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_pending_ff <= 1'b1;
         half_held_ff     <= 1'b0;
         little_endian_ff <= 1'b1;
      end else begin
         first_pending_ff <= first_pending_in;
         half_held_ff     <= half_held_in;
         little_endian_ff <= little_endian_in;
      end
      held_byte_ff <= held_byte_in;
   end

endmodule
`default_nettype wire

### sv/u2u8_queue.sv
// Small FIFO of classified code units between front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module u2u8_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push_valid,
   input  wire u2u8_pkg::unit_entry_type push_entry,
   output logic                          push_ready,
   output logic                          pop_valid,
   output u2u8_pkg::unit_entry_type      pop_entry,
   input  wire logic                     pop_ready
);

   u2u8_pkg::unit_entry_type slots_ff [u2u8_pkg::Q_DEPTH];

   logic [u2u8_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [u2u8_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [u2u8_pkg::Q_CNT_W-1:0] count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign push_ready = (count_ff != u2u8_pkg::Q_CNT_W'(u2u8_pkg::Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == u2u8_pkg::Q_PTR_W'(u2u8_pkg::Q_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == u2u8_pkg::Q_PTR_W'(u2u8_pkg::Q_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

### sv/u2u8_back.sv
// Back end: serializes one code unit into its UTF-8 bytes through an output register.
`timescale 1ns / 1ps
`default_nettype none
module u2u8_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     pop_valid,
   input  wire u2u8_pkg::unit_entry_type pop_entry,
   output logic                          pop_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_last_of_run,
   output logic                          rsp_odd_length_error
);

   u2u8_pkg::byte_idx_type idx_ff, idx_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       err_ff, err_in;

   logic       load;
   logic       final_byte;
   logic [7:0] sel_byte;
   logic [15:0] u;

   assign u          = pop_entry.unit;
   assign load       = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign final_byte = (idx_ff == pop_entry.last_idx);
   assign pop_ready  = load && final_byte;

   always_comb begin
      sel_byte = {u2u8_pkg::CONT_TAG, u[5:0]};
      case (pop_entry.last_idx)
         u2u8_pkg::LAST_IDX_1: begin
            sel_byte = pop_entry.odd_err ? 8'h00 : u[7:0];
         end
         u2u8_pkg::LAST_IDX_2: begin
            if (idx_ff == 2'd0) begin
               sel_byte = {u2u8_pkg::LEAD2_TAG, u[10:6]};
            end
         end
         default: begin
            if (idx_ff == 2'd0) begin
               sel_byte = {u2u8_pkg::LEAD3_TAG, u[15:12]};
            end else if (idx_ff == 2'd1) begin
               sel_byte = {u2u8_pkg::CONT_TAG, u[11:6]};
            end
         end
      endcase
   end

   always_comb begin
      idx_in       = idx_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_valid_in = 1'b1;
         byte_in      = sel_byte;
         last_in      = final_byte;
         err_in       = pop_entry.odd_err;
         idx_in       = final_byte ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_byte         = byte_ff;
   assign rsp_last_of_run      = last_ff;
   assign rsp_odd_length_error = err_ff;

endmodule
`default_nettype wire
